// ----- rtl/core/fbdt_pkg.sv -----
// Shared constants and types for the file block dedup table.
package fbdt_pkg;
    localparam int TableDepth   = 4096;
    localparam int IdxBits      = $clog2(TableDepth);
    localparam int CntBits      = IdxBits + 1;
    localparam int PosBits      = 48;
    localparam int HashBits     = 57;
    localparam int SizeBits     = 25;
    localparam int BytesBits    = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PLACE,
        ST_LAST,
        ST_OUTER,
        ST_RDA,
        ST_RDB,
        ST_CMP,
        ST_OFFRD,
        ST_OFFWT,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               wr_en;
        logic [IdxBits-1:0] wr_idx;
        logic [HashBits-1:0] wr_hash;
        logic [PosBits-1:0] wr_off;
        logic [IdxBits-1:0] rd_idx;
    } t_mem_req;
endpackage

// ----- rtl/core/fbdt_store.sv -----
// Entry store: hash and offset memory with registered read.
module fbdt_store
    import fbdt_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [HashBits-1:0] o_hash,
    output logic [PosBits-1:0]  o_off
);
    logic [HashBits-1:0] r_hash_mem [TableDepth];
    logic [PosBits-1:0]  r_off_mem  [TableDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_hash_mem[i_req.wr_idx] <= i_req.wr_hash;
            r_off_mem[i_req.wr_idx]  <= i_req.wr_off;
        end
        o_hash <= r_hash_mem[i_req.rd_idx];
        o_off  <= r_off_mem[i_req.rd_idx];
    end
endmodule

// ----- rtl/core/file_block_dedup_table.sv -----
// Top level: block placement and file-level dedup search sequencer.
// A non-last item goes from placement straight to the result; a last item of an empty file
// adds a last step, and a last item with entries also runs the shared-comparator search.
// Throughput: one item in flight; busy stays high through the result strobe.
// Reset: synchronous, active low; clears counters and positions, not the table.
// Results are shown for one cycle on o_valid; the receiver cannot stall.
module file_block_dedup_table
    import fbdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_first_block,
    input  logic                 i_last_block,
    input  logic [BytesBits-1:0] i_block_bytes,
    input  logic                 i_compressed,
    input  logic [31:0]          i_block_checksum,
    output logic                 o_valid,
    output logic                 o_placed,
    output logic [PosBits-1:0]   o_block_offset,
    output logic [SizeBits-1:0]  o_size_word,
    output logic                 o_file_done,
    output logic [PosBits-1:0]   o_file_start_offset,
    output logic                 o_duplicate,
    output logic [CntBits-1:0]   o_erased_blocks,
    output logic [PosBits-1:0]   o_erased_bytes,
    output logic                 o_status
);
    t_state r_state, n_state;
    logic [CntBits-1:0] r_count, n_count, r_ffe, n_ffe, r_fs, n_fs;
    logic [CntBits-1:0] r_i, n_i, r_j, n_j, r_start, n_start;
    logic [PosBits-1:0] r_wpos, n_wpos, r_fspos, n_fspos;
    logic [HashBits-1:0] r_ha, n_ha;
    logic r_last, r_first, r_comp;
    logic [BytesBits-1:0] r_bytes;
    logic [31:0] r_chk;
    logic r_placed, n_placed, r_status, n_status, r_dup, n_dup;
    logic [PosBits-1:0] r_boff, n_boff, r_fso, n_fso, r_eby, n_eby;
    logic [SizeBits-1:0] r_sw, n_sw;
    logic [CntBits-1:0] r_eblk, n_eblk;
    t_mem_req s_req;
    logic [HashBits-1:0] s_hash;
    logic [PosBits-1:0] s_off;
    logic [SizeBits-1:0] s_sw;
    logic [CntBits-1:0] s_cnt;

    fbdt_store u_store (.i_clk(i_clk), .i_req(s_req), .o_hash(s_hash), .o_off(s_off));

    assign s_sw  = {~r_comp, r_bytes};
    assign s_cnt = r_count - r_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ffe   <= '0;
            r_wpos  <= '0;
            r_fspos <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ffe   <= n_ffe;
            r_wpos  <= n_wpos;
            r_fspos <= n_fspos;
        end
        if (start && !busy) begin
            r_first <= i_first_block;
            r_last  <= i_last_block;
            r_bytes <= i_block_bytes;
            r_comp  <= i_compressed;
            r_chk   <= i_block_checksum;
        end
        r_fs <= n_fs; r_i <= n_i; r_j <= n_j; r_start <= n_start; r_ha <= n_ha;
        r_placed <= n_placed; r_status <= n_status; r_dup <= n_dup;
        r_boff <= n_boff; r_fso <= n_fso; r_eby <= n_eby; r_sw <= n_sw;
        r_eblk <= n_eblk;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_PLACE;
            ST_PLACE:  n_state = r_last ? ST_LAST : ST_DONE;
            ST_LAST:   n_state = (r_fs >= r_count) ? ST_DONE : ST_OUTER;
            ST_OUTER:  n_state = (r_i == r_fs) ? ST_OFFRD :
                                 (r_j == s_cnt) ? ST_OFFRD : ST_RDA;
            ST_RDA:    n_state = ST_RDB;
            ST_RDB:    n_state = ST_CMP;
            ST_CMP:    n_state = ST_OUTER;
            ST_OFFRD:  n_state = ST_OFFWT;
            ST_OFFWT:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count; n_ffe = r_ffe; n_wpos = r_wpos; n_fspos = r_fspos;
        n_fs = r_fs; n_i = r_i; n_j = r_j; n_start = r_start; n_ha = r_ha;
        n_placed = r_placed; n_status = r_status; n_dup = r_dup;
        n_boff = r_boff; n_fso = r_fso; n_eby = r_eby; n_sw = r_sw; n_eblk = r_eblk;
        s_req = '{wr_en: 1'b0, wr_idx: '0, wr_hash: '0, wr_off: '0, rd_idx: '0};
        unique case (r_state)
            ST_IDLE: begin
                n_placed = 1'b0; n_status = 1'b0; n_dup = 1'b0;
                n_boff = '0; n_fso = '0; n_eby = '0; n_sw = '0; n_eblk = '0;
            end
            ST_PLACE: begin
                if (r_first) begin
                    n_fspos = r_wpos;
                    n_ffe   = r_count;
                end
                if (r_bytes != '0) begin
                    if (r_count >= CntBits'(TableDepth)) begin
                        n_status = 1'b1;
                    end else begin
                        s_req.wr_en   = 1'b1;
                        s_req.wr_idx  = r_count[IdxBits-1:0];
                        s_req.wr_hash = {s_sw, r_chk};
                        s_req.wr_off  = r_wpos;
                        n_count  = r_count + 1'b1;
                        n_wpos   = r_wpos + PosBits'(r_bytes);
                        n_placed = 1'b1;
                        n_boff   = r_wpos;
                        n_sw     = s_sw;
                    end
                end
                n_fs = r_first ? r_count : r_ffe;
            end
            ST_LAST: begin
                if (r_fs > r_count) n_fs = r_count;
                n_i = '0; n_j = '0;
                if (r_fs >= r_count) n_fso = r_wpos;
            end
            ST_OUTER: begin
                if (r_i == r_fs) n_start = r_fs;
                else if (r_j == s_cnt) n_start = r_i;
                s_req.rd_idx = IdxBits'(r_i + r_j);
            end
            ST_RDA: begin
                n_ha = s_hash;
                s_req.rd_idx = IdxBits'(r_fs + r_j);
            end
            ST_RDB: s_req.rd_idx = IdxBits'(r_fs + r_j);
            ST_CMP: begin
                if (r_ha == s_hash) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                end
            end
            ST_OFFRD: s_req.rd_idx = IdxBits'(r_start);
            ST_OFFWT: s_req.rd_idx = IdxBits'(r_start);
            ST_FINISH: begin
                n_fso = s_off;
                if (r_start < r_fs) begin
                    n_dup = 1'b1;
                    n_eby = r_wpos - r_fspos;
                    n_wpos = r_fspos;
                    if (r_start + s_cnt >= r_fs) begin
                        n_eblk  = r_count - (r_start + s_cnt);
                        n_count = r_start + s_cnt;
                    end else begin
                        n_eblk  = s_cnt;
                        n_count = r_fs;
                    end
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_valid             = (r_state == ST_DONE);
    assign o_placed            = r_placed;
    assign o_block_offset      = r_boff;
    assign o_size_word         = r_sw;
    assign o_file_done         = r_last;
    assign o_file_start_offset = r_fso;
    assign o_duplicate         = r_dup;
    assign o_erased_blocks     = r_eblk;
    assign o_erased_bytes      = r_eby;
    assign o_status            = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(TableDepth)) else $error("entry count overflow");
    a_dup_erased: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_duplicate |-> o_file_done) else $error("duplicate without file end");
    a_place_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_placed && o_status)) else $error("placed and full");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the file block dedup table.
module tb;
    import fbdt_pkg::*;

    localparam int CycleLimit = 20000000;

    typedef struct {
        bit                 first;
        bit                 last;
        bit [BytesBits-1:0] bytes;
        bit                 comp;
        bit [31:0]          chk;
        bit                 drain;
    } t_blk_item;

    typedef struct {
        bit                 placed;
        bit [PosBits-1:0]   off;
        bit [SizeBits-1:0]  size;
        bit                 done;
        bit [PosBits-1:0]   start_off;
        bit                 dup;
        bit [CntBits-1:0]   eblk;
        bit [PosBits-1:0]   ebytes;
        bit                 status;
    } t_placement;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_first_block = 1'b0;
    logic i_last_block = 1'b0;
    logic [BytesBits-1:0] i_block_bytes = '0;
    logic i_compressed = 1'b0;
    logic [31:0] i_block_checksum = '0;
    logic o_valid, o_placed, o_file_done, o_duplicate, o_status;
    logic [PosBits-1:0] o_block_offset, o_file_start_offset, o_erased_bytes;
    logic [SizeBits-1:0] o_size_word;
    logic [CntBits-1:0] o_erased_blocks;

    file_block_dedup_table uut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_blk_item  pending_blocks[$];
    t_placement expected_placements[$];
    t_blk_item  cur_blk;
    int errors = 0, sent = 0, total_items = 0, cycles = 0;
    int idle_pct = 19, dup_seen = 0, full_seen = 0, overlap_seen = 0;

    bit [HashBits-1:0] hash_tab[TableDepth];
    bit [PosBits-1:0]  off_tab[TableDepth];
    int n_entries = 0, first_entry = 0;
    bit [PosBits-1:0] file_pos = '0, wr_pos = '0;

    task automatic place_block(input t_blk_item b);
        t_placement r;
        bit [SizeBits-1:0] sw;
        int fs, cnt, hit, i, j, fin;
        r = '{default: '0};
        if (b.first) begin
            file_pos = wr_pos;
            first_entry = n_entries;
        end
        if (b.bytes != 0) begin
            sw = {~b.comp, b.bytes};
            if (n_entries >= TableDepth) begin
                r.status = 1'b1;
                full_seen++;
            end else begin
                off_tab[n_entries] = wr_pos;
                hash_tab[n_entries] = {sw, b.chk};
                n_entries++;
                r.placed = 1'b1;
                r.off = wr_pos;
                r.size = sw;
                wr_pos = wr_pos + b.bytes;
            end
        end
        if (b.last) begin
            fs = (first_entry > n_entries) ? n_entries : first_entry;
            cnt = n_entries - fs;
            r.done = 1'b1;
            if (cnt == 0) begin
                r.start_off = wr_pos;
            end else begin
                hit = fs;
                for (i = 0; i < fs && hit == fs; i++) begin
                    for (j = 0; j < cnt; j++)
                        if (hash_tab[i + j] != hash_tab[fs + j]) break;
                    if (j == cnt) hit = i;
                end
                r.start_off = off_tab[hit];
                if (hit < fs) begin
                    fin = hit + cnt;
                    if (fin >= fs) begin
                        r.eblk = n_entries - fin;
                        n_entries = fin;
                        overlap_seen++;
                    end else begin
                        r.eblk = cnt;
                        n_entries = fs;
                    end
                    r.dup = 1'b1;
                    r.ebytes = wr_pos - file_pos;
                    wr_pos = file_pos;
                    dup_seen++;
                end
            end
        end
        expected_placements.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                place_block(cur_blk);
                sent++;
            end
            if (pending_blocks.size() > 0
                && !(pending_blocks[0].drain && expected_placements.size() > 0)
                && $urandom_range(99) >= idle_pct) begin
                cur_blk = pending_blocks.pop_front();
                i_first_block <= cur_blk.first;
                i_last_block <= cur_blk.last;
                i_block_bytes <= cur_blk.bytes;
                i_compressed <= cur_blk.comp;
                i_block_checksum <= cur_blk.chk;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
            if (sent < total_items / 3) idle_pct = 19;
            else if (sent < 2 * total_items / 3) idle_pct = 76;
            else idle_pct = 0;
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_placement e;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (expected_placements.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = expected_placements.pop_front();
                check_field("placed", e.placed, o_placed);
                check_field("block_offset", e.off, o_block_offset);
                check_field("size_word", e.size, o_size_word);
                check_field("file_done", e.done, o_file_done);
                check_field("file_start_offset", e.start_off, o_file_start_offset);
                check_field("duplicate", e.dup, o_duplicate);
                check_field("erased_blocks", e.eblk, o_erased_blocks);
                check_field("erased_bytes", e.ebytes, o_erased_bytes);
                check_field("status", e.status, o_status);
            end
        end
    end

    task automatic push_blk(input bit f, input bit l, input bit [23:0] b,
                            input bit c, input bit [31:0] k, input bit d = 1'b0);
        t_blk_item x;
        x = '{first: f, last: l, bytes: b, comp: c, chk: k, drain: d};
        pending_blocks.push_back(x);
    endtask

    t_blk_item lib[32][6];
    int lib_len[32];
    int lib_n = 0;

    initial begin
        int n, src, k;
        bit fresh;
        t_blk_item b;

        push_blk(1, 1, 0, 0, 0);
        push_blk(1, 0, 24'hFFFFFF, 0, 32'hFFFFFFFF);
        push_blk(0, 1, 1, 1, 0);
        push_blk(1, 0, 24'hFFFFFF, 0, 32'hFFFFFFFF);
        push_blk(0, 1, 1, 1, 0);
        push_blk(1, 1, 100, 1, 32'h5A5A5A5A);
        push_blk(1, 1, 100, 0, 32'h5A5A5A5A);
        push_blk(0, 1, 0, 1, 32'h12345678);
        push_blk(1, 0, 7, 1, 32'hA);
        push_blk(0, 1, 7, 1, 32'hA, 1);
        push_blk(1, 0, 7, 1, 32'hA);
        push_blk(0, 0, 7, 1, 32'hA);
        push_blk(0, 1, 7, 1, 32'hA);
        push_blk(0, 1, 9, 0, 32'hB);
        push_blk(0, 0, 0, 0, 0);
        push_blk(1, 0, 24'h800000, 1, 32'h80000000);
        push_blk(0, 1, 24'h7FFFFF, 0, 32'h7FFFFFFF);

        while (pending_blocks.size() < 1550) begin
            if ($urandom_range(99) < 25) begin
                push_blk($urandom_range(1), $urandom_range(1),
                         ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom),
                         $urandom_range(1), $urandom,
                         $urandom_range(199) == 0);
            end else begin
                fresh = (lib_n == 0) || ($urandom_range(99) < 50);
                src = (lib_n == 0) ? 0 : (lib_n - 1 - $urandom_range(lib_n < 8 ? lib_n - 1 : 7));
                n = fresh ? $urandom_range(1, 6) : lib_len[src % 32];
                for (k = 0; k < n; k++) begin
                    if (fresh) begin
                        if ($urandom_range(3) == 0) begin
                            b.bytes = 24'($urandom_range(1, 4));
                            b.chk = $urandom_range(3);
                        end else begin
                            b.bytes = ($urandom_range(9) == 0) ? 24'($urandom)
                                                               : 24'($urandom_range(1, 4096));
                            b.chk = $urandom;
                        end
                        b.comp = $urandom_range(1);
                        if ($urandom_range(19) == 0) b.bytes = 0;
                    end else begin
                        b = lib[src % 32][k];
                        if ($urandom_range(19) == 0) b.chk = $urandom;
                    end
                    lib[lib_n % 32][k] = b;
                    push_blk(k == 0, k == n - 1, b.bytes, b.comp, b.chk,
                             k == 0 && $urandom_range(99) == 0);
                end
                lib_len[lib_n % 32] = n;
                lib_n++;
            end
        end

        push_blk(0, 1, 50, 1, $urandom);
        push_blk(1, 1, 0, 0, 0);
        push_blk(0, 0, 24'hFFFFFF, 0, 32'hFFFFFFFF);
        total_items = pending_blocks.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_blocks.size() > 0 || start || expected_placements.size() > 0);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d blocks: %0d duplicate files (%0d overlapping), %0d full-table drops",
                 sent, dup_seen, overlap_seen, full_seen);
        if (errors == 0 && expected_placements.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
